[hw/rtl/srtf_pkg.sv]
// Shared types and constants for the SRTF process scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int DEF_MAX_PROCESSES = 8;
  localparam int DEF_TIME_BITS     = 16;
  localparam int INDEX_W           = 3;
  localparam int CFG_W             = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_ARRIVED  = 2'd0,
    EV_SELECTED = 2'd1,
    EV_FINISHED = 2'd2,
    EV_IDLE     = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic run;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic blocked;
    logic out_free;
    logic hold_valid;
    logic scan_done;
    logic arr_hit;
    logic found;
    logic need_sel;
    logic fin_hit;
  } dp_status_t;

endpackage

[hw/rtl/srtf_ctrl.sv]
// Controller state machine for the SRTF process scheduler.
`timescale 1ns / 1ps

module srtf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  output logic                in_ready,
  input  srtf_pkg::dp_status_t status,
  output srtf_pkg::dp_cmd_t    cmd
);
  import srtf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && op == OP_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!(status.blocked && (!status.found || status.need_sel))) begin
          state_next = status.found ? ST_RUN : ST_FLUSH;
        end
      end
      ST_RUN: begin
        if (!(status.blocked && status.fin_hit)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.hold_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = !rst;
        cmd.load       = !rst && in_valid && op == OP_LOAD;
        cmd.scan_start = !rst && in_valid && op == OP_TICK;
      end
      ST_SCAN: begin
        cmd.scan_step = !status.scan_done && !(status.arr_hit && status.blocked);
      end
      ST_PICK: begin
        cmd.pick = !(status.blocked && (!status.found || status.need_sel));
      end
      ST_RUN: begin
        cmd.run = !(status.blocked && status.fin_hit);
      end
      ST_FLUSH: begin
        cmd.flush = !status.hold_valid || status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/srtf_dp.sv]
// Datapath for the SRTF process scheduler: process tables, scan, result staging.
`timescale 1ns / 1ps

module srtf_dp #(
  parameter int MAX_PROCESSES = srtf_pkg::DEF_MAX_PROCESSES,
  parameter int TIME_BITS     = srtf_pkg::DEF_TIME_BITS,
  parameter int OUT_DATA_W    = ((srtf_pkg::INDEX_W + 4 * TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srtf_pkg::dp_cmd_t             cmd,
  output srtf_pkg::dp_status_t          status,
  input  logic [srtf_pkg::INDEX_W-1:0]  entry_index,
  input  logic [TIME_BITS-1:0]          arrival,
  input  logic [TIME_BITS-1:0]          burst,
  input  logic                          cfg_we,
  input  logic [srtf_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [OUT_DATA_W-1:0]         out_data,
  output srtf_pkg::ev_t                 out_ev,
  output logic                          out_last
);
  import srtf_pkg::*;

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [TIME_BITS-1:0] arrival_mem   [MAX_PROCESSES];
  logic [TIME_BITS-1:0] burst_mem     [MAX_PROCESSES];
  logic [TIME_BITS-1:0] remaining_mem [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] arrived;
  logic [MAX_PROCESSES-1:0] loaded;

  logic [CFG_W-1:0]     process_count;
  logic [TIME_BITS-1:0] cur_time;
  logic [IDX_W-1:0]     last_running;
  logic                 last_running_valid;

  logic [CNT_W-1:0]     scan_cnt;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_rem;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_burst;

  logic                 hold_valid;
  logic [OUT_DATA_W-1:0] hold_data;
  ev_t                  hold_ev;

  logic [CNT_W-1:0]     count_eff;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     ld_idx;
  logic                 ld_in_range;
  logic [TIME_BITS-1:0] s_arr;
  logic [TIME_BITS-1:0] s_rem;
  logic                 arr_hit;
  logic                 s_ready;
  logic                 take;
  logic                 out_free;
  logic                 blocked;
  logic                 need_sel;
  logic                 fin_hit;

  logic [TIME_BITS:0]   fin;
  logic [TIME_BITS:0]   ta_full;
  logic [TIME_BITS:0]   used;
  logic [TIME_BITS-1:0] ta_sat;
  logic [TIME_BITS-1:0] wt_val;

  logic                 new_valid;
  ev_t                  new_ev;
  logic [INDEX_W-1:0]   new_idx;
  logic [TIME_BITS-1:0] new_at;
  logic [TIME_BITS-1:0] new_rem;
  logic [TIME_BITS-1:0] new_wt;
  logic [TIME_BITS-1:0] new_ta;
  logic [OUT_DATA_W-1:0] new_data;
  logic                 out_load;

  always_comb begin
    if (32'(process_count) > MAX_PROCESSES) begin
      count_eff = CNT_W'(MAX_PROCESSES);
    end else begin
      count_eff = CNT_W'(process_count);
    end
  end

  assign scan_idx    = scan_cnt[IDX_W-1:0];
  assign ld_idx      = IDX_W'(entry_index);
  assign ld_in_range = 32'(entry_index) < MAX_PROCESSES;

  assign s_arr   = arrival_mem[scan_idx];
  assign s_rem   = remaining_mem[scan_idx];
  assign arr_hit = s_arr == cur_time && !arrived[scan_idx];
  assign s_ready = loaded[scan_idx] && s_arr <= cur_time && s_rem != '0;
  assign take    = s_ready && (!found || s_rem <= best_rem);

  assign out_free = !out_valid || out_ready;
  assign blocked  = hold_valid && !out_free;
  assign need_sel = found && (!last_running_valid || last_running != best_idx);
  assign fin_hit  = best_rem == TIME_BITS'(1);

  // finish time and turnaround are taken without wrap
  assign fin     = {1'b0, cur_time} + 1'b1;
  assign ta_full = fin - {1'b0, best_arr};
  assign ta_sat  = ta_full[TIME_BITS] ? TIME_MAX : ta_full[TIME_BITS-1:0];
  assign used    = {1'b0, best_burst} + {1'b0, best_arr};
  assign wt_val  = (fin > used) ? TIME_BITS'(fin - used) : '0;

  always_comb begin
    status.blocked    = blocked;
    status.out_free   = out_free;
    status.hold_valid = hold_valid;
    status.scan_done  = scan_cnt == count_eff;
    status.arr_hit    = arr_hit;
    status.found      = found;
    status.need_sel   = need_sel;
    status.fin_hit    = fin_hit;
  end

  always_comb begin
    new_valid = 1'b0;
    new_ev    = EV_IDLE;
    new_idx   = '0;
    new_at    = cur_time;
    new_rem   = '0;
    new_wt    = '0;
    new_ta    = '0;
    if (cmd.scan_step && arr_hit) begin
      new_valid = 1'b1;
      new_ev    = EV_ARRIVED;
      new_idx   = INDEX_W'(scan_idx);
    end else if (cmd.pick && !found) begin
      new_valid = 1'b1;
      new_ev    = EV_IDLE;
    end else if (cmd.pick && need_sel) begin
      new_valid = 1'b1;
      new_ev    = EV_SELECTED;
      new_idx   = INDEX_W'(best_idx);
      new_rem   = best_rem;
    end else if (cmd.run && fin_hit) begin
      new_valid = 1'b1;
      new_ev    = EV_FINISHED;
      new_idx   = INDEX_W'(best_idx);
      new_at    = fin[TIME_BITS-1:0];
      new_wt    = wt_val;
      new_ta    = ta_sat;
    end
  end

  assign new_data = OUT_DATA_W'({new_ta, new_wt, new_rem, new_at, new_idx});
  assign out_load = hold_valid && (new_valid || cmd.flush);

  // process tables
  always_ff @(posedge clk) begin
    if (cmd.load && ld_in_range) begin
      arrival_mem[ld_idx]   <= arrival;
      burst_mem[ld_idx]     <= burst;
      remaining_mem[ld_idx] <= burst;
    end else if (cmd.run) begin
      remaining_mem[best_idx] <= best_rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrived            <= '0;
      loaded             <= '0;
      process_count      <= CFG_RESET;
      cur_time           <= '0;
      last_running       <= '0;
      last_running_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end
      if (cmd.load && ld_in_range) begin
        arrived[ld_idx] <= 1'b0;
        loaded[ld_idx]  <= 1'b1;
        if (last_running == ld_idx) begin
          last_running_valid <= 1'b0;
        end
      end
      if (cmd.scan_step && arr_hit) begin
        arrived[scan_idx] <= 1'b1;
      end
      if (cmd.pick && need_sel) begin
        last_running       <= best_idx;
        last_running_valid <= 1'b1;
      end
      if (cmd.flush) begin
        cur_time <= cur_time + 1'b1;
      end
    end
  end

  // scan and best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + 1'b1;
      if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_idx   <= scan_idx;
      best_rem   <= s_rem;
      best_arr   <= s_arr;
      best_burst <= burst_mem[scan_idx];
    end
  end

  // one result is held back until it is known whether it ends the tick
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (new_valid) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      hold_data <= new_data;
      hold_ev   <= new_ev;
    end
    if (out_load) begin
      out_data <= hold_data;
      out_ev   <= hold_ev;
      out_last <= cmd.flush;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("held result moved onto a stalled output");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !hold_valid)
    else $error("result left in holding register after tick end");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    found |-> best_rem != '0)
    else $error("picked process with nothing remaining");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> scan_cnt < count_eff)
    else $error("scan ran past the process count");

endmodule

[hw/rtl/srtf_process_scheduler.sv]
// Top level of the shortest-remaining-time-first process scheduler.
//
// Input stream (s_axis_*): tuser = operation (0 load, 1 tick); tdata carries
// entry_index, arrival and burst. A load writes one table entry and returns
// nothing and leaves the block idle, so the next item is taken the cycle after.
// A tick reports arrivals at the current time, selects the ready process with
// the least remaining burst (ties to the highest index), runs it one unit and
// reports its finish if it completes, or reports idle. The last result of a tick has tlast.
// Output stream (m_axis_*): tuser = event, tdata carries the result fields.
// With n = process_count capped at MAX_PROCESSES, a tick steps through accept,
// a scan over each of the n table entries, scan end, pick, run and flush, with
// run skipped when nothing is ready; it gives at most n + 2 results. Results
// leave through a single output register; one result is staged before it so
// tlast can be set, so the first result of a tick passes through the staging
// register and then the output register. A stalled receiver holds the scan
// at the next result and no transfer is lost.
// cfg_we/cfg_wdata set process_count; write only between ticks.
// Synchronous reset clears time, arrival marks, the last running process and
// sets process_count to 1; no input is taken while reset is high; table
// contents are undefined until loaded.
`timescale 1ns / 1ps

module srtf_process_scheduler #(
  parameter int MAX_PROCESSES = srtf_pkg::DEF_MAX_PROCESSES,
  parameter int TIME_BITS     = srtf_pkg::DEF_TIME_BITS,
  parameter int IN_DATA_W     = ((srtf_pkg::INDEX_W + 2 * TIME_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_W    = ((srtf_pkg::INDEX_W + 4 * TIME_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_index, arrival, burst
  input  logic [IN_DATA_W-1:0]       s_axis_tdata,
  // operation
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // process_index, at_time, remaining_burst, wait_time, turnaround_time
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // event_res
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  input  logic                       cfg_we,
  input  logic [srtf_pkg::CFG_W-1:0] cfg_wdata
);
  import srtf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  ev_t        out_ev;

  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .op       (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srtf_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS),
    .OUT_DATA_W    (OUT_DATA_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .entry_index (s_axis_tdata[INDEX_W-1:0]),
    .arrival     (s_axis_tdata[INDEX_W +: TIME_BITS]),
    .burst       (s_axis_tdata[INDEX_W + TIME_BITS +: TIME_BITS]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata),
    .out_ev      (out_ev),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tuser = out_ev;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the SRTF process scheduler: loads, ticks, count settings.
`timescale 1ns / 1ps

module testbench;
  import srtf_pkg::*;

  localparam int SLOTS = DEF_MAX_PROCESSES;

  typedef struct packed {
    ev_t         ev;
    logic [2:0]  pidx;
    logic [15:0] at;
    logic [15:0] rem;
    logic [15:0] wt;
    logic [15:0] ta;
    logic        is_last;
  } sched_event_t;

  class srtf_scoreboard;
    logic [15:0]  arr_tab[SLOTS];
    logic [15:0]  burst_tab[SLOTS];
    logic [15:0]  rem_tab[SLOTS];
    bit           arrived[SLOTS];
    logic [15:0]  now;
    logic [2:0]   run_idx;
    bit           run_valid;
    logic [3:0]   proc_count;
    sched_event_t expected[$];
    int           errors, n_checked, n_loads, n_ticks;
    int           n_ev[4];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        arr_tab[i] = '0;
        burst_tab[i] = '0;
        rem_tab[i] = '0;
        arrived[i] = 1'b0;
      end
      now = '0;
      run_idx = '0;
      run_valid = 1'b0;
      proc_count = CFG_RESET;
      errors = 0;
      n_checked = 0;
      n_loads = 0;
      n_ticks = 0;
      n_ev = '{0, 0, 0, 0};
    endfunction

    function sched_event_t make_event(ev_t ev, logic [2:0] pidx, logic [15:0] at,
                                      logic [15:0] rem, logic [15:0] wt, logic [15:0] ta);
      sched_event_t e;
      e.ev = ev;
      e.pidx = pidx;
      e.at = at;
      e.rem = rem;
      e.wt = wt;
      e.ta = ta;
      e.is_last = 1'b0;
      return e;
    endfunction

    // Update the schedule state for one accepted input transfer and queue its events.
    function void note_transfer_in(logic op, logic [2:0] idx, logic [15:0] arr,
                                   logic [15:0] bst);
      int           lim;
      int           pick;
      bit           found;
      logic [15:0]  best;
      logic [16:0]  fin, span, used, late;
      sched_event_t batch[$];
      if (op == OP_LOAD) begin
        n_loads++;
        arr_tab[idx] = arr;
        burst_tab[idx] = bst;
        rem_tab[idx] = bst;
        arrived[idx] = 1'b0;
        if (run_valid && run_idx == idx) run_valid = 1'b0;
        return;
      end
      n_ticks++;
      lim = (proc_count > SLOTS) ? SLOTS : int'(proc_count);
      found = 1'b0;
      pick = 0;
      best = '0;
      for (int i = 0; i < lim; i++) begin
        if (arr_tab[i] == now && !arrived[i]) begin
          batch.push_back(make_event(EV_ARRIVED, 3'(i), now, '0, '0, '0));
          arrived[i] = 1'b1;
        end
        if (arr_tab[i] <= now && rem_tab[i] != 0 && (!found || rem_tab[i] <= best)) begin
          best = rem_tab[i];
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        batch.push_back(make_event(EV_IDLE, 3'd0, now, '0, '0, '0));
      end else begin
        if (!run_valid || run_idx != 3'(pick)) begin
          batch.push_back(make_event(EV_SELECTED, 3'(pick), now, rem_tab[pick], '0, '0));
          run_idx = 3'(pick);
          run_valid = 1'b1;
        end
        rem_tab[pick] = rem_tab[pick] - 16'd1;
        if (rem_tab[pick] == 0) begin
          // finish time and turnaround are taken without wrap, turnaround saturates
          fin = {1'b0, now} + 17'd1;
          span = fin - {1'b0, arr_tab[pick]};
          if (span > 17'h0FFFF) span = 17'h0FFFF;
          used = {1'b0, burst_tab[pick]} + {1'b0, arr_tab[pick]};
          late = (fin > used) ? fin - used : 17'd0;
          batch.push_back(make_event(EV_FINISHED, 3'(pick), fin[15:0], '0, late[15:0],
                                     span[15:0]));
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].is_last = 1'b1;
      foreach (batch[k]) expected.push_back(batch[k]);
      now = now + 16'd1;
    endfunction

    function void flag(string why, sched_event_t want, sched_event_t got);
      errors++;
      if (errors <= 10)
        $display("[%0t] %s: expected ev=%0d idx=%0d t=%0d rem=%0d wait=%0d ta=%0d last=%0d",
                 $time, why, want.ev, want.pidx, want.at, want.rem, want.wt, want.ta,
                 want.is_last,
                 "\n      got      ev=%0d idx=%0d t=%0d rem=%0d wait=%0d ta=%0d last=%0d",
                 got.ev, got.pidx, got.at, got.rem, got.wt, got.ta, got.is_last);
    endfunction

    function void check_transfer_out(ev_t ev, logic [2:0] pidx, logic [15:0] at,
                                     logic [15:0] rem, logic [15:0] wt, logic [15:0] ta,
                                     logic is_last);
      sched_event_t got, want;
      got = make_event(ev, pidx, at, rem, wt, ta);
      got.is_last = is_last;
      n_checked++;
      n_ev[got.ev]++;
      if (expected.size() == 0) begin
        flag("unexpected transfer", got, got);
        return;
      end
      want = expected.pop_front();
      if (got !== want) flag("mismatch", want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // entry_index, arrival, burst
  logic [39:0] s_axis_tdata  = '0;
  // operation
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // process_index, at_time, remaining_burst, wait_time, turnaround_time
  logic [71:0] m_axis_tdata;
  // event_res
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic [3:0]  cfg_wdata     = '0;

  srtf_scoreboard sb = new();
  int tx_gap_pct = 0;
  int rx_gap_pct = 0;
  bit squeeze_req = 1'b0;

  srtf_process_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("timeout: %0d events still outstanding", sb.expected.size());
    $display("testbench NOT OK");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(logic op, logic [2:0] idx, logic [15:0] arr, logic [15:0] bst);
    int gap;
    gap = (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, bst, arr, idx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_transfer_in(op, idx, arr, bst);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait until every expected event is out, then let a tick with no events finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.proc_count = v;
  endtask

  // receiver: checks every output transfer and paces tready
  initial begin
    int hold;
    hold = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_transfer_out(ev_t'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tdata[18:3],
                              m_axis_tdata[34:19], m_axis_tdata[50:35], m_axis_tdata[66:51],
                              m_axis_tlast);
      if (squeeze_req) begin
        hold = 400;
        squeeze_req = 1'b0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
        m_axis_tready <= 1'b0;
        hold = gap_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    int          count_plan[9];
    int          mode;
    logic [15:0] arr, bst;
    count_plan = '{8, 1, 15, 4, 0, 6, 2, 8, 12};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every slot before any tick reads it; includes both field extremes
    send_item(OP_LOAD, 3'd0, 16'd0, 16'd3);
    send_item(OP_LOAD, 3'd1, 16'd0, 16'd3);
    send_item(OP_LOAD, 3'd2, 16'd2, 16'd1);
    send_item(OP_LOAD, 3'd3, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 3'd4, 16'd1, 16'd2);
    send_item(OP_LOAD, 3'd5, 16'd4, 16'd1);
    send_item(OP_LOAD, 3'd6, 16'd3, 16'd5);
    send_item(OP_LOAD, 3'd7, 16'd5, 16'd1);
    // reset count of one, second tick continues the same process silently
    send_tick();
    send_tick();
    // over-range count acts as full table; equal remaining goes to the higher slot
    write_count(4'd15);
    repeat (6) send_tick();
    // reload the running process so it must be selected again
    send_item(OP_LOAD, sb.run_idx, 16'd0, 16'd2);
    repeat (3) send_tick();
    write_count(4'd0);
    repeat (2) send_tick();

    for (int p = 0; p < 9; p++) begin
      write_count(4'(count_plan[p]));
      tx_gap_pct = (p == 0 || p % 3 == 1) ? 0 : 30;
      rx_gap_pct = (p % 3 == 1) ? 0 : 30;
      if (p == 0) squeeze_req = 1'b1;
      repeat (18) begin
        if ($urandom_range(0, 99) < 40) begin
          mode = $urandom_range(0, 99);
          if (mode < 60) arr = sb.now + 16'($urandom_range(0, 6));
          else if (mode < 75) arr = sb.now - 16'($urandom_range(1, 8));
          else arr = 16'($urandom);
          mode = $urandom_range(0, 99);
          if (mode < 70) bst = 16'($urandom_range(1, 6));
          else if (mode < 85) bst = 16'($urandom_range(7, 40));
          else bst = 16'($urandom_range(1, 65535));
          send_item(OP_LOAD, 3'($urandom), arr, bst);
        end else begin
          send_tick();
        end
      end
    end

    settle();
    $display("covered %0d loads and %0d ticks, counts 0 to 15, long receiver stall",
             sb.n_loads, sb.n_ticks);
    $display("%0d events checked: arrived %0d selected %0d finished %0d idle %0d, %0d errors",
             sb.n_checked, sb.n_ev[EV_ARRIVED], sb.n_ev[EV_SELECTED], sb.n_ev[EV_FINISHED],
             sb.n_ev[EV_IDLE], sb.errors);
    if (sb.expected.size() != 0)
      $display("%0d expected events never arrived", sb.expected.size());
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
